/* hdl/assert_macros.svh */
// Assertion macros shared by the matrix multiply/blend RTL.
// No dependencies; define NO_ASSERTIONS to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define MMB_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed (same cycle)");

// next-cycle implication
`define MMB_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed (next cycle)");

`else

`define MMB_ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define MMB_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

/* hdl/mmb_pkg.sv */
// Shared types, constants and the saturation helper for the matrix unit.
// No dependencies.
package mmb_pkg;

    localparam int DEF_FRAC_BITS = 16;
    // storage word; equals the 32-bit width of the stream fields
    localparam int WORD_BITS     = 32;
    localparam int OPA_BITS      = WORD_BITS + 1;      // blend difference
    localparam int PROD_BITS     = OPA_BITS + WORD_BITS;
    localparam int ACC_BITS      = 2 * WORD_BITS + 4;
    localparam int LANES         = 4;

    localparam int S_TDATA_BITS  = 168;
    localparam int M_TDATA_BITS  = 136;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_MULT  = 2'd1,
        CMD_BLEND = 2'd2,
        CMD_IDENT = 2'd3
    } cmd_t;

    typedef logic signed [WORD_BITS-1:0] word_t;
    typedef logic signed [OPA_BITS-1:0]  opa_t;
    typedef logic signed [PROD_BITS-1:0] prod_t;
    typedef logic signed [ACC_BITS-1:0]  acc_t;

    // control that goes with one result row
    typedef struct packed {
        logic [1:0] row;
        logic       last;
    } beat_ctrl_t;

    localparam acc_t WORD_MAX_ACC = {{(ACC_BITS-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}};
    localparam acc_t WORD_MIN_ACC = ~WORD_MAX_ACC;

    function automatic word_t sat_word(input acc_t v);
        word_t r;
        if (v > WORD_MAX_ACC) begin
            r = WORD_MAX_ACC[WORD_BITS-1:0];
        end else if (v < WORD_MIN_ACC) begin
            r = WORD_MIN_ACC[WORD_BITS-1:0];
        end else begin
            r = v[WORD_BITS-1:0];
        end
        return r;
    endfunction

endpackage

/* hdl/mmb_lane.sv */
// One arithmetic lane: four registered products, then sum, shift, saturate.
// Depends on mmb_pkg.
module mmb_lane #(
    parameter int FRAC_BITS = mmb_pkg::DEF_FRAC_BITS
) (
    input  logic          aclk,
    input  logic          en,
    input  mmb_pkg::opa_t  a [mmb_pkg::LANES],
    input  mmb_pkg::word_t b [mmb_pkg::LANES],
    input  mmb_pkg::acc_t  addend,
    output mmb_pkg::word_t result
);
    import mmb_pkg::*;

    prod_t prod_reg [LANES];
    acc_t  addend_reg;
    acc_t  sum;
    acc_t  shifted;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < LANES; i++) begin
                prod_reg[i] <= prod_t'(a[i]) * prod_t'(b[i]);
            end
            addend_reg <= addend;
        end
    end

    always_comb begin
        sum = addend_reg;
        for (int i = 0; i < LANES; i++) begin
            sum = sum + acc_t'(prod_reg[i]);
        end
        shifted = sum >>> FRAC_BITS;   // floor division
        result  = sat_word(shifted);
    end

endmodule

/* hdl/mmb_out_stage.sv */
// Merge stage: packs the four lane results into one beat and holds it
// in the output register until the sink takes it. Depends on mmb_pkg.
module mmb_out_stage (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               push,
    input  mmb_pkg::beat_ctrl_t                ctrl,
    input  mmb_pkg::word_t                     lane_res [mmb_pkg::LANES],
    output logic                               in_ready,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // m_tdata: [1:0] out_row, [33:2] out0, [65:34] out1, [97:66] out2,
    //          [129:98] out3, rest zero
    output logic [mmb_pkg::M_TDATA_BITS-1:0]   m_tdata,
    // m_tlast: last_row
    output logic                               m_tlast
);
    import mmb_pkg::*;

    localparam int PAD_BITS = M_TDATA_BITS - 2 - LANES * WORD_BITS;

    logic       valid_reg;
    logic [1:0] row_reg;
    logic       last_reg;
    word_t      data_reg [LANES];

    assign in_ready = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (push) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
        if (push) begin
            row_reg  <= ctrl.row;
            last_reg <= ctrl.last;
            data_reg <= lane_res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {{PAD_BITS{1'b0}}, data_reg[3], data_reg[2], data_reg[1], data_reg[0],
                       row_reg};

endmodule

/* hdl/matrix4_multiply_blend_unit.sv */
// Top level of the 4x4 fixed-point matrix multiply/blend unit.
// Depends on mmb_pkg, mmb_lane, mmb_out_stage and assert_macros.svh.
//
// The unit keeps a 4x4 current matrix of signed fixed-point words
// (FRAC_BITS fraction bits, 32-bit words, identity after reset). Each input
// beat carries a command in s_tuser and one row in s_tdata. Load, identity
// and multiply operand rows 0..2 update the registers and emit nothing.
// Blend holds the input off through ST_MUL and ST_ACC and emits the
// updated row, tlast set. Multiply operand row 3 starts a run of four
// result rows: each row passes through ST_MUL (product capture in the
// four lanes) and ST_ACC (sum/shift/saturate and write back), and the
// input is held off for the whole run; ST_ACC also waits while the output
// register is stalled. There are four lanes, one per output column,
// each with four multipliers. A finished beat waits in the output register
// while the next input is taken. Operand rows 0..2 are undefined until
// written; rows may arrive in any order and a rewrite replaces the older
// row. Products are floored by the shift and saturated to 32 bits.
module matrix4_multiply_blend_unit #(
    parameter int FRAC_BITS = mmb_pkg::DEF_FRAC_BITS
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // s_tdata: [1:0] row_index, [33:2] elem0, [65:34] elem1, [97:66] elem2,
    //          [129:98] elem3, [161:130] blend_factor, rest zero
    input  logic [mmb_pkg::S_TDATA_BITS-1:0]   s_tdata,
    // s_tuser: [1:0] command
    input  logic [1:0]                         s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // m_tdata: [1:0] out_row, [33:2] out0, [65:34] out1, [97:66] out2,
    //          [129:98] out3, rest zero
    output logic [mmb_pkg::M_TDATA_BITS-1:0]   m_tdata,
    // m_tlast: last_row
    output logic                               m_tlast
);
    import mmb_pkg::*;

`include "assert_macros.svh"

    localparam word_t ONE = word_t'(1) <<< FRAC_BITS;

    typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_ACC} state_t;

    // registers
    state_t     state_reg,  state_next;
    word_t      mat_reg    [4][4];
    word_t      mat_next   [4][4];
    word_t      op_reg     [3][4];      // operand rows 0..2
    word_t      op_next    [3][4];
    word_t      e_reg      [4];         // row of the beat in flight
    word_t      e_next     [4];
    word_t      factor_reg, factor_next;
    logic [1:0] row_reg,    row_next;
    logic       blend_reg,  blend_next;
    logic [1:0] rcnt_reg,   rcnt_next;

    // input beat fields
    cmd_t       cmd_in;
    logic [1:0] row_in;
    word_t      elem_in    [4];
    word_t      factor_in;
    logic       s_accept;

    // lane wiring
    logic [1:0] rd_row;
    logic       lane_en;
    opa_t       lane_a     [LANES][LANES];
    word_t      lane_b     [LANES][LANES];
    acc_t       lane_add   [LANES];
    word_t      lane_res   [LANES];

    logic       push;
    logic       out_ready;
    beat_ctrl_t beat_ctrl;

    assign cmd_in    = cmd_t'(s_tuser);
    assign row_in    = s_tdata[1:0];
    assign factor_in = s_tdata[2 + 4*WORD_BITS +: WORD_BITS];
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            elem_in[c] = s_tdata[2 + c*WORD_BITS +: WORD_BITS];
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;

    // blend works on its own row, multiply walks rows 0..3
    assign rd_row  = blend_reg ? row_reg : rcnt_reg;
    assign lane_en = (state_reg == ST_MUL);

    // lane operands: lane c produces output column c
    always_comb begin
        for (int c = 0; c < LANES; c++) begin
            if (blend_reg) begin
                for (int i = 0; i < LANES; i++) begin
                    lane_a[c][i] = '0;
                    lane_b[c][i] = '0;
                end
                lane_a[c][0] = opa_t'(e_reg[c]) - opa_t'(mat_reg[rd_row][c]);
                lane_b[c][0] = factor_reg;
                // cur + floor(d*f / 2^F) == floor((d*f + cur*2^F) / 2^F)
                lane_add[c]  = acc_t'(mat_reg[rd_row][c]) <<< FRAC_BITS;
            end else begin
                for (int i = 0; i < 3; i++) begin
                    lane_a[c][i] = opa_t'(mat_reg[rd_row][i]);
                    lane_b[c][i] = op_reg[i][c];
                end
                lane_a[c][3] = opa_t'(mat_reg[rd_row][3]);
                lane_b[c][3] = e_reg[c];    // operand row 3 comes from the beat
                lane_add[c]  = '0;
            end
        end
    end

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        mmb_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .aclk   (aclk),
            .en     (lane_en),
            .a      (lane_a[g]),
            .b      (lane_b[g]),
            .addend (lane_add[g]),
            .result (lane_res[g])
        );
    end

    assign push           = (state_reg == ST_ACC) && out_ready;
    assign beat_ctrl.row  = rd_row;
    assign beat_ctrl.last = blend_reg || (rcnt_reg == 2'd3);

    mmb_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .ctrl     (beat_ctrl),
        .lane_res (lane_res),
        .in_ready (out_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // sequencer
    always_comb begin
        state_next  = state_reg;
        mat_next    = mat_reg;
        op_next     = op_reg;
        e_next      = e_reg;
        factor_next = factor_reg;
        row_next    = row_reg;
        blend_next  = blend_reg;
        rcnt_next   = rcnt_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    unique case (cmd_in)
                        CMD_LOAD: begin
                            mat_next[row_in] = elem_in;
                        end
                        CMD_IDENT: begin
                            for (int r = 0; r < 4; r++) begin
                                for (int c = 0; c < 4; c++) begin
                                    mat_next[r][c] = (r == c) ? ONE : '0;
                                end
                            end
                        end
                        CMD_MULT: begin
                            if (row_in == 2'd3) begin
                                e_next     = elem_in;
                                blend_next = 1'b0;
                                rcnt_next  = '0;
                                state_next = ST_MUL;
                            end else begin
                                op_next[row_in] = elem_in;
                            end
                        end
                        CMD_BLEND: begin
                            e_next      = elem_in;
                            factor_next = factor_in;
                            row_next    = row_in;
                            blend_next  = 1'b1;
                            state_next  = ST_MUL;
                        end
                        default: ;
                    endcase
                end
            end
            ST_MUL: begin
                state_next = ST_ACC;
            end
            ST_ACC: begin
                if (out_ready) begin
                    // a result row depends only on its own old row
                    mat_next[rd_row] = lane_res;
                    if (blend_reg || (rcnt_reg == 2'd3)) begin
                        state_next = ST_IDLE;
                    end else begin
                        rcnt_next  = rcnt_reg + 2'd1;
                        state_next = ST_MUL;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            blend_reg <= 1'b0;
            rcnt_reg  <= '0;
            for (int r = 0; r < 4; r++) begin
                for (int c = 0; c < 4; c++) begin
                    mat_reg[r][c] <= (r == c) ? ONE : '0;
                end
            end
        end else begin
            state_reg <= state_next;
            blend_reg <= blend_next;
            rcnt_reg  <= rcnt_next;
            mat_reg   <= mat_next;
        end
        op_reg     <= op_next;
        e_reg      <= e_next;
        factor_reg <= factor_next;
        row_reg    <= row_next;
    end

    // checks
    `MMB_ASSERT_IMPLY(a_push_room, aclk, aresetn, push, out_ready)
    `MMB_ASSERT_NEXT(a_mul_start, aclk, aresetn, s_accept && (cmd_in == CMD_MULT) && (row_in == 2'd3), state_reg == ST_MUL && rcnt_reg == 2'd0)
    `MMB_ASSERT_NEXT(a_stall_hold, aclk, aresetn, (state_reg == ST_ACC) && !out_ready, (state_reg == ST_ACC) && $stable(rcnt_reg))
    `MMB_ASSERT_NEXT(a_ident, aclk, aresetn, s_accept && (cmd_in == CMD_IDENT), (mat_reg[3][3] == ONE) && (mat_reg[0][1] == '0))

endmodule
